@@ design/iasmd_pkg.sv @@
// Package: shared widths, command codes and control struct for the arithmetic unit.
`timescale 1ns / 1ps
package iasmd_pkg;

  localparam int WIDTH   = 32;
  localparam int RES_W   = 2 * WIDTH;
  localparam int ADD_W   = WIDTH + 2;
  localparam int CNT_W   = $clog2(WIDTH);

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_SUB = 2'd1;
  localparam cmd_t CMD_MUL = 2'd2;
  localparam cmd_t CMD_DIV = 2'd3;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic step;
    cmd_t cmd;
  } ctrl_t;

endpackage

@@ design/iasmd_if.sv @@
// Interfaces: command/operand input channel and result output channel.
`timescale 1ns / 1ps
interface iasmd_in_if;
  logic                       valid;
  logic                       ready;
  iasmd_pkg::cmd_t            cmd;
  logic [iasmd_pkg::WIDTH-1:0] operand_a;
  logic [iasmd_pkg::WIDTH-1:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

interface iasmd_out_if;
  logic                        valid;
  logic                        ready;
  logic [iasmd_pkg::RES_W-1:0] result;
  logic [iasmd_pkg::WIDTH-1:0] remainder;
  logic                        div_by_zero;

  modport source (output valid, output result, output remainder, output div_by_zero,
                  input ready);
  modport sink   (input valid, input result, input remainder, input div_by_zero,
                  output ready);
endinterface

@@ design/iasmd_datapath.sv @@
// Datapath: operand registers and the one shared adder used by every command.
`timescale 1ns / 1ps
module iasmd_datapath (
  input  logic                         clk,
  input  iasmd_pkg::ctrl_t             ctl,
  input  logic [iasmd_pkg::WIDTH-1:0]  a,
  input  logic [iasmd_pkg::WIDTH-1:0]  b,
  output logic [iasmd_pkg::WIDTH-1:0]  hi,
  output logic [iasmd_pkg::WIDTH-1:0]  lo
);

  localparam int W  = iasmd_pkg::WIDTH;
  localparam int AW = iasmd_pkg::ADD_W;

  logic [W-1:0]  hi_r, hi_nxt;
  logic [W-1:0]  lo_r, lo_nxt;
  logic [W-1:0]  b_r;
  logic [AW-1:0] add_x, add_y, sum;
  logic          add_cin;
  logic          ge;

  // shared adder operand selection
  always_comb begin
    add_x   = {2'b00, lo_r};
    add_y   = {2'b00, b_r};
    add_cin = 1'b0;
    case (ctl.cmd)
      iasmd_pkg::CMD_ADD: begin
        add_x = {2'b00, lo_r};
        add_y = {2'b00, b_r};
      end
      iasmd_pkg::CMD_SUB: begin
        add_x   = {2'b00, lo_r};
        add_y   = {2'b00, ~b_r};
        add_cin = 1'b1;
      end
      iasmd_pkg::CMD_MUL: begin
        add_x = {2'b00, hi_r};
        add_y = lo_r[0] ? {2'b00, b_r} : '0;
      end
      iasmd_pkg::CMD_DIV: begin
        // shifted partial remainder minus divisor
        add_x   = {1'b0, hi_r, lo_r[W-1]};
        add_y   = ~{2'b00, b_r};
        add_cin = 1'b1;
      end
      default: begin
        add_x = {2'b00, lo_r};
      end
    endcase
  end

  assign sum = add_x + add_y + {{(AW-1){1'b0}}, add_cin};
  assign ge  = ~sum[AW-1];

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (ctl.load) begin
      hi_nxt = '0;
      lo_nxt = a;
    end else if (ctl.step) begin
      case (ctl.cmd)
        iasmd_pkg::CMD_ADD,
        iasmd_pkg::CMD_SUB: begin
          hi_nxt = '0;
          lo_nxt = sum[W-1:0];
        end
        iasmd_pkg::CMD_MUL: begin
          hi_nxt = sum[W:1];
          lo_nxt = {sum[0], lo_r[W-1:1]};
        end
        iasmd_pkg::CMD_DIV: begin
          hi_nxt = ge ? sum[W-1:0] : {hi_r[W-2:0], lo_r[W-1]};
          lo_nxt = {lo_r[W-2:0], ge};
        end
        default: begin
          hi_nxt = hi_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (ctl.load) begin
      b_r <= b;
    end
  end

  assign hi = hi_r;
  assign lo = lo_r;

endmodule

@@ design/iasmd_ctrl.sv @@
// Sequencer: accepts a transaction, counts datapath steps, holds the result for output.
`timescale 1ns / 1ps
module iasmd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  iasmd_pkg::cmd_t   in_cmd,
  input  logic              in_b_zero,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              dz,
  output iasmd_pkg::ctrl_t  ctl
);

  localparam int CW = iasmd_pkg::CNT_W;
  localparam logic [CW-1:0] LAST = CW'(iasmd_pkg::WIDTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  iasmd_pkg::cmd_t cmd_r;
  logic            dz_r;
  logic            accept;
  logic            one_step;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign accept    = in_valid && in_ready;
  assign one_step  = (cmd_r == iasmd_pkg::CMD_ADD) || (cmd_r == iasmd_pkg::CMD_SUB);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_BUSY;
          cnt_nxt   = '0;
        end
      end
      S_BUSY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (one_step || cnt_r == LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      dz_r  <= (in_cmd == iasmd_pkg::CMD_DIV) && in_b_zero;
    end
  end

  always_comb begin
    ctl.load = accept;
    ctl.step = (state_r == S_BUSY);
    ctl.cmd  = cmd_r;
  end

  assign dz = dz_r;

  ap_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_BUSY) && (cnt_r == '0))
    else $error("accepted transaction did not start the sequencer");

  ap_iter_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUSY) && !one_step && (cnt_r != LAST) |=> (state_r == S_BUSY))
    else $error("multiply/divide left the iteration early");

  ap_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUSY) && one_step |=> (state_r == S_DONE))
    else $error("add/subtract took more than one step");

  ap_dz_div_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && dz_r |-> (cmd_r == iasmd_pkg::CMD_DIV))
    else $error("divide-by-zero flag on a non-divide command");

  ap_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !out_ready |=> (state_r == S_DONE) && $stable(cmd_r))
    else $error("pending result dropped before it was taken");

endmodule

@@ design/iterative_add_sub_mul_div_unit.sv @@
// Top level: iterative add/subtract/multiply/divide unit.
// Steps: add/subtract take one shared-adder step after the load; multiply/divide
//   take one shared-adder step per operand bit after the load.
// One transaction at a time: the next accept can come in the cycle after the result is
//   taken, so a new transaction is not accepted while a result is still pending.
// Reset: synchronous active-low rst_n returns the sequencer to idle; data regs are not reset.
`timescale 1ns / 1ps
module iterative_add_sub_mul_div_unit (
  input  logic          clk,
  input  logic          rst_n,
  iasmd_in_if.sink      in_if,
  iasmd_out_if.source   out_if
);

  localparam int W = iasmd_pkg::WIDTH;

  iasmd_pkg::ctrl_t ctl;   // load/step strobes and latched command
  logic [W-1:0]     hi;    // product high half, or partial remainder
  logic [W-1:0]     lo;    // sum/difference, product low half, or quotient
  logic             dz;

  // Sequencer: idle -> busy (1 or WIDTH steps) -> done until out_if.ready.
  iasmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_cmd    (in_if.cmd),
    .in_b_zero (in_if.operand_b == '0),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .dz        (dz),
    .ctl       (ctl)
  );

  // Datapath: one 34-bit adder serves add, subtract, shift-add multiply
  // and restoring divide (trial subtract of the shifted partial remainder).
  // A zero divisor needs no special path: every trial subtract succeeds,
  // giving an all-ones quotient and the dividend as remainder.
  iasmd_datapath u_dp (
    .clk (clk),
    .ctl (ctl),
    .a   (in_if.operand_a),
    .b   (in_if.operand_b),
    .hi  (hi),
    .lo  (lo)
  );

  // Result formatting. hi is zero after add/subtract, so only divide needs
  // to steer it away from the upper result half.
  always_comb begin
    out_if.result      = {hi, lo};
    out_if.remainder   = '0;
    out_if.div_by_zero = dz;
    if (ctl.cmd == iasmd_pkg::CMD_DIV) begin
      out_if.result    = {{W{1'b0}}, lo};
      out_if.remainder = hi;
    end
  end

endmodule
